// File: rtl/bmp_pixel_stream_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
// Both expect clk and arst_n in the scope where they are used.
`ifndef BMP_PIXEL_STREAM_DECODER_MACROS_SVH
`define BMP_PIXEL_STREAM_DECODER_MACROS_SVH

// Same-cycle implication
`define BMPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BMPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bmpd_pkg.sv
package bmpd_pkg;

	// Default image bounds
	localparam int unsigned DEF_MAX_WIDTH  = 4096;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;

	// Parse phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_SKIP   = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_PAD    = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	// Result kinds
	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_FILL   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
	localparam logic [2:0] ST_BAD_HDR    = 3'd2;
	localparam logic [2:0] ST_BAD_OFFSET = 3'd3;
	localparam logic [2:0] ST_TOO_LARGE  = 3'd4;

	// Header layout (little-endian byte positions)
	localparam logic [31:0] POS_MAGIC_HI = 32'd1;
	localparam logic [31:0] POS_OFS_LO   = 32'd10;
	localparam logic [31:0] POS_OFS_HI   = 32'd13;
	localparam logic [31:0] POS_HSZ_LO   = 32'd14;
	localparam logic [31:0] POS_HSZ_HI   = 32'd17;
	localparam logic [31:0] POS_W_LO     = 32'd18;
	localparam logic [31:0] POS_W_HI     = 32'd21;
	localparam logic [31:0] POS_H_LO     = 32'd22;
	localparam logic [31:0] POS_H_HI     = 32'd25;
	localparam logic [31:0] POS_BPP_LO   = 32'd28;
	localparam logic [31:0] POS_BPP_HI   = 32'd29;
	localparam logic [31:0] POS_STRIDE   = 32'd30;
	localparam logic [31:0] POS_HDR_END  = 32'd53;

	localparam logic [15:0] BMP_MAGIC     = 16'h4D42;
	localparam logic [7:0]  INFO_HDR_SIZE = 8'd40;
	localparam logic [31:0] MIN_OFFSET    = 32'd54;
	localparam logic [1:0]  GROUP_LEN     = 2'd3;
	localparam logic [7:0]  FILL_RESET    = 8'd255;

	// One output word
	typedef struct packed {
		logic [7:0] val;
		logic [1:0] kind;
		logic [2:0] status;
		logic       last;
	} res_t;

endpackage

// File: rtl/bmp_pixel_stream_decoder.sv
// Channel | Handshake            | Word
// --------+----------------------+-------------------------------------
// in      | in_valid / in_ready  | in_byte, first_byte
// out     | out_valid / out_ready| out_byte, out_kind, status, last
// cfg     | cfg_we (no wait)     | cfg_wdata -> fill byte
//
// One input word per cycle enters the input stage while in_ready is high; its
// parse step is combinational and is registered into a two-entry result buffer.
// A word yields 0, 1 or 2 result words; the buffer drains one per cycle while
// out_ready is high; a data word ending a 3-byte group or the image adds a fill.
// arst_n clears the parse to idle and sets the fill byte to 0xFF.
// A stalled output holds a non-empty buffer and backs up into in_ready.
`include "bmp_pixel_stream_decoder_macros.svh"

module bmp_pixel_stream_decoder
	import bmpd_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       first_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic [2:0] status,
	output logic       last,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned PW = 16 + WW;
	localparam int unsigned SW = PW - 3;

	// Input stage
	logic       valid_s1;
	logic [7:0] in_byte_s1;
	logic       first_s1;

	// Parse state
	logic [2:0]    phase_q, phase_d;
	logic [31:0]   pos_q, pos_d;
	logic [31:0]   offset_q, offset_d;
	logic [31:0]   width_q, width_d;
	logic [31:0]   height_q, height_d;
	logic [15:0]   bpp_q, bpp_d;
	logic [7:0]    magic_lo_q, magic_lo_d;
	logic          hdr_ok_q, hdr_ok_d;
	logic [SW-1:0] stride_q, stride_d;
	logic [SW-1:0] rbs_q, rbs_d;
	logic [HW-1:0] rows_q, rows_d;
	logic [1:0]    grp_q, grp_d;
	logic [1:0]    padl_q, padl_d;
	logic [7:0]    fill_q;

	// Result buffer
	res_t       r0_q, r1_q;
	logic [1:0] cnt_q;

	// Step logic
	logic [2:0]    ph;
	logic [31:0]   pos;
	logic [31:0]   pos_inc;
	logic [1:0]    lane;
	logic          start_req;
	logic          empty_img;
	logic [PW-1:0] prod;
	logic [1:0]    pad_row;
	logic [SW-1:0] rbs_inc;
	logic [HW-1:0] rows_inc;
	logic [1:0]    grp_inc;
	logic          row_end;
	logic          img_end;
	res_t          res_a, res_b;
	logic [1:0]    n_res;
	logic          go;

	// Handshake
	assign go       = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready));
	assign in_ready = !valid_s1 || go;

	assign out_valid = (cnt_q != 2'd0);
	assign out_byte  = r0_q.val;
	assign out_kind  = r0_q.kind;
	assign status    = r0_q.status;
	assign last      = r0_q.last;

	// Derived row geometry
	assign prod      = PW'(bpp_q) * PW'(width_q[WW-1:0]);
	assign pad_row   = 2'(2'd0 - stride_q[1:0]);
	assign empty_img = (height_q[HW-1:0] == '0) || (stride_q == '0);
	assign rbs_inc   = rbs_q + SW'(1);
	assign rows_inc  = rows_q + HW'(1);
	assign grp_inc   = grp_q + 2'd1;
	assign row_end   = (rbs_inc == stride_q);
	assign img_end   = row_end && (rows_inc == height_q[HW-1:0]);

	// One parse step for the word in the input stage
	always_comb begin
		ph         = first_s1 ? PH_HEADER : phase_q;
		pos        = first_s1 ? 32'd0 : pos_q;
		pos_inc    = pos + 32'd1;
		lane       = pos[1:0] + 2'd2;
		start_req  = 1'b0;
		phase_d    = ph;
		pos_d      = pos;
		offset_d   = offset_q;
		width_d    = width_q;
		height_d   = height_q;
		bpp_d      = bpp_q;
		magic_lo_d = magic_lo_q;
		hdr_ok_d   = hdr_ok_q;
		stride_d   = stride_q;
		rbs_d      = rbs_q;
		rows_d     = rows_q;
		grp_d      = grp_q;
		padl_d     = padl_q;
		n_res      = 2'd0;
		res_a      = '{val: 8'd0, kind: KIND_STATUS, status: ST_OK, last: 1'b1};
		res_b      = '{val: fill_q, kind: KIND_FILL, status: ST_OK, last: 1'b0};

		unique case (ph)
			PH_HEADER: begin
				pos_d = pos_inc;
				// field capture
				if (pos == 32'd0)
					magic_lo_d = in_byte_s1;
				if (pos >= POS_OFS_LO && pos <= POS_OFS_HI)
					offset_d[{lane, 3'b000} +: 8] = in_byte_s1;
				if (pos >= POS_W_LO && pos <= POS_W_HI)
					width_d[{lane, 3'b000} +: 8] = in_byte_s1;
				if (pos >= POS_H_LO && pos <= POS_H_HI)
					height_d[{lane, 3'b000} +: 8] = in_byte_s1;
				if (pos == POS_BPP_LO)
					bpp_d[7:0] = in_byte_s1;
				if (pos == POS_BPP_HI)
					bpp_d[15:8] = in_byte_s1;
				if (pos == POS_HSZ_LO)
					hdr_ok_d = (in_byte_s1 == INFO_HDR_SIZE);
				else if (pos > POS_HSZ_LO && pos < POS_HSZ_HI)
					hdr_ok_d = hdr_ok_q && (in_byte_s1 == 8'd0);

				// checks, in header order
				priority if (pos == POS_MAGIC_HI) begin
					if (!(magic_lo_q == BMP_MAGIC[7:0] && in_byte_s1 == BMP_MAGIC[15:8])) begin
						n_res        = 2'd1;
						res_a.status = ST_BAD_MAGIC;
						phase_d      = PH_DONE;
					end
				end else if (pos == POS_HSZ_HI) begin
					if (!(hdr_ok_q && in_byte_s1 == 8'd0)) begin
						n_res        = 2'd1;
						res_a.status = ST_BAD_HDR;
						phase_d      = PH_DONE;
					end else if (offset_q < MIN_OFFSET) begin
						n_res        = 2'd1;
						res_a.status = ST_BAD_OFFSET;
						phase_d      = PH_DONE;
					end
				end else if (pos == POS_H_HI) begin
					if (width_q > 32'(MAX_WIDTH) || height_d > 32'(MAX_HEIGHT)) begin
						n_res        = 2'd1;
						res_a.status = ST_TOO_LARGE;
						phase_d      = PH_DONE;
					end
				end else if (pos == POS_STRIDE) begin
					stride_d = prod[PW-1:3];
				end else if (pos == POS_HDR_END) begin
					phase_d   = PH_SKIP;
					start_req = (pos_inc == offset_q);
				end else begin
				end
			end
			PH_SKIP: begin
				pos_d     = pos_inc;
				start_req = (pos_inc == offset_q);
			end
			PH_DATA: begin
				res_a = '{val: in_byte_s1, kind: KIND_PIXEL, status: ST_OK, last: 1'b0};
				n_res = 2'd1;
				grp_d = (grp_inc == GROUP_LEN) ? 2'd0 : grp_inc;
				if (grp_inc == GROUP_LEN || img_end) begin
					n_res      = 2'd2;
					res_b.last = img_end;
				end
				rbs_d = rbs_inc;
				if (row_end) begin
					rbs_d  = '0;
					rows_d = rows_inc;
					if (img_end) begin
						phase_d = PH_DONE;
					end else if (pad_row != 2'd0) begin
						padl_d  = pad_row;
						phase_d = PH_PAD;
					end
				end
			end
			PH_PAD: begin
				padl_d = padl_q - 2'd1;
				if (padl_d == 2'd0)
					phase_d = PH_DATA;
			end
			default: begin
			end
		endcase

		// pixel data begins at the data offset
		if (start_req) begin
			if (empty_img) begin
				n_res        = 2'd1;
				res_a.status = ST_OK;
				phase_d      = PH_DONE;
			end else begin
				phase_d = PH_DATA;
				rbs_d   = '0;
				rows_d  = '0;
				grp_d   = 2'd0;
				padl_d  = 2'd0;
			end
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_byte_s1 <= in_byte;
			first_s1   <= first_byte;
		end
	end

	// Parse control state and fill register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			rbs_q   <= '0;
			rows_q  <= '0;
			grp_q   <= '0;
			padl_q  <= '0;
			fill_q  <= FILL_RESET;
		end else begin
			if (go) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				rbs_q   <= rbs_d;
				rows_q  <= rows_d;
				grp_q   <= grp_d;
				padl_q  <= padl_d;
			end
			if (cfg_we)
				fill_q <= cfg_wdata;
		end
	end

	// Captured header fields
	always_ff @(posedge clk) begin
		if (go) begin
			offset_q   <= offset_d;
			width_q    <= width_d;
			height_q   <= height_d;
			bpp_q      <= bpp_d;
			magic_lo_q <= magic_lo_d;
			hdr_ok_q   <= hdr_ok_d;
			stride_q   <= stride_d;
		end
	end

	// Result buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (go) begin
			cnt_q <= n_res;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Result buffer words
	always_ff @(posedge clk) begin
		if (go) begin
			r0_q <= res_a;
			r1_q <= res_b;
		end else if (out_valid && out_ready) begin
			r0_q <= r1_q;
		end
	end

	`BMPD_ASSERT_NOW(a_buf_cnt, 1'b1, cnt_q != 2'd3, "result buffer count out of range")
	`BMPD_ASSERT_NOW(a_second_is_fill, cnt_q == 2'd2, r1_q.kind == KIND_FILL,
		"second buffered word is not a fill byte")
	`BMPD_ASSERT_NOW(a_status_word, out_valid && out_kind == KIND_STATUS,
		last && out_byte == 8'd0, "status word without last or with data")
	`BMPD_ASSERT_NOW(a_data_geom, phase_q == PH_DATA,
		stride_q != '0 && rows_q < height_q[HW-1:0], "data phase with bad geometry")
	`BMPD_ASSERT_NEXT(a_first_starts, go && first_s1, phase_q != PH_IDLE,
		"first byte did not start a parse")

endmodule

// File: bench/tb_bmp_pixel_stream_decoder.sv
`timescale 1ns / 1ps

module tb_bmp_pixel_stream_decoder;
	import bmpd_pkg::*;

	localparam logic [31:0] HSZ_OK = 32'(INFO_HDR_SIZE);

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       first_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic [2:0] status;
	logic       last;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	// Decoder state as the bench tracks it
	logic [2:0]  dec_phase;
	logic [31:0] byte_pos;
	logic [31:0] data_ofs;
	logic [31:0] hdr_size;
	logic [31:0] img_w;
	logic [31:0] img_h;
	logic [15:0] pix_bits;
	logic [15:0] magic_seen;
	logic [31:0] stride;
	logic [31:0] row_seen;
	logic [31:0] rows;
	logic [1:0]  pad_left;
	logic [1:0]  pad_per_row;
	logic [1:0]  grp;
	logic [7:0]  fill_model = FILL_RESET;

	res_t        expected_words[$];
	logic [7:0]  file_bytes[$];

	bit          pacing = 1'b1;
	int          hold_off_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned words_checked = 0;
	int unsigned status_seen = 0;
	int unsigned files_sent = 0;
	int unsigned bytes_sent = 0;
	int unsigned fill_writes = 0;

	bmp_pixel_stream_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.first_byte(first_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_kind  (out_kind),
		.status    (status),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Decode predictor
	// ---------------------------------------------------------------
	function automatic res_t word_of(logic [7:0] v, logic [1:0] k, logic [2:0] s, logic l);
		res_t w;
		w.val = v;
		w.kind = k;
		w.status = s;
		w.last = l;
		return w;
	endfunction

	task automatic clear_decode();
		dec_phase = PH_IDLE;
		byte_pos = '0;
		data_ofs = '0;
		hdr_size = '0;
		img_w = '0;
		img_h = '0;
		pix_bits = '0;
		magic_seen = '0;
		stride = '0;
		row_seen = '0;
		rows = '0;
		pad_left = '0;
		pad_per_row = '0;
		grp = '0;
	endtask

	// status-only word closes the file
	task automatic post_status(input logic [2:0] code);
		expected_words.push_back(word_of(8'h00, KIND_STATUS, code, 1'b1));
		dec_phase = PH_DONE;
	endtask

	// offset reached: empty images end here
	task automatic enter_data();
		if (img_h == 0 || stride == 0) begin
			post_status(ST_OK);
		end else begin
			dec_phase = PH_DATA;
			row_seen = '0;
			rows = '0;
			grp = '0;
			pad_left = '0;
		end
	endtask

	task automatic predict_decode(input logic [7:0] b, input logic f);
		res_t        w[2];
		int          n;
		logic [31:0] p;
		logic [63:0] prod;
		n = 0;
		if (f) begin
			clear_decode();
			dec_phase = PH_HEADER;
		end
		case (dec_phase)
			PH_HEADER: begin
				p = byte_pos;
				// little-endian field capture
				if (p <= POS_MAGIC_HI)
					magic_seen[8*p[0] +: 8] = b;
				else if (p >= POS_OFS_LO && p <= POS_OFS_HI)
					data_ofs[8*(p - POS_OFS_LO) +: 8] = b;
				else if (p >= POS_HSZ_LO && p <= POS_HSZ_HI)
					hdr_size[8*(p - POS_HSZ_LO) +: 8] = b;
				else if (p >= POS_W_LO && p <= POS_W_HI)
					img_w[8*(p - POS_W_LO) +: 8] = b;
				else if (p >= POS_H_LO && p <= POS_H_HI)
					img_h[8*(p - POS_H_LO) +: 8] = b;
				else if (p >= POS_BPP_LO && p <= POS_BPP_HI)
					pix_bits[8*(p - POS_BPP_LO) +: 8] = b;
				byte_pos++;
				if (p == POS_MAGIC_HI) begin
					if (magic_seen != BMP_MAGIC) post_status(ST_BAD_MAGIC);
				end else if (p == POS_HSZ_HI) begin
					if (hdr_size != HSZ_OK) post_status(ST_BAD_HDR);
					else if (data_ofs < MIN_OFFSET) post_status(ST_BAD_OFFSET);
				end else if (p == POS_H_HI) begin
					if (img_w > DEF_MAX_WIDTH || img_h > DEF_MAX_HEIGHT)
						post_status(ST_TOO_LARGE);
				end else if (p == POS_BPP_HI) begin
					prod = 64'(pix_bits) * 64'(img_w);
					stride = prod[34:3];
					pad_per_row = 2'd0 - stride[1:0];
				end else if (p == POS_HDR_END) begin
					dec_phase = PH_SKIP;
					if (byte_pos == data_ofs) enter_data();
				end
			end
			PH_SKIP: begin
				byte_pos++;
				if (byte_pos == data_ofs) enter_data();
			end
			PH_DATA: begin
				w[n] = word_of(b, KIND_PIXEL, ST_OK, 1'b0);
				n++;
				grp++;
				if (grp == GROUP_LEN) begin
					w[n] = word_of(fill_model, KIND_FILL, ST_OK, 1'b0);
					n++;
					grp = '0;
				end
				row_seen++;
				if (row_seen == stride) begin
					row_seen = '0;
					rows++;
					if (rows == img_h) begin
						// partial group gets one closing fill
						if (grp != 0) begin
							w[n] = word_of(fill_model, KIND_FILL, ST_OK, 1'b0);
							n++;
							grp = '0;
						end
						w[n-1].last = 1'b1;
						dec_phase = PH_DONE;
					end else if (pad_per_row != 0) begin
						pad_left = pad_per_row;
						dec_phase = PH_PAD;
					end
				end
			end
			PH_PAD: begin
				pad_left--;
				if (pad_left == 0) dec_phase = PH_DATA;
			end
			default: ;
		endcase
		for (int i = 0; i < n; i++) expected_words.push_back(w[i]);
	endtask

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic f);
		int gap;
		gap = (pacing && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		first_byte <= f;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_decode(b, f);
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_byte(8'($urandom), 1'b0);
	endtask

	// whole file, or its first count bytes when count is positive
	task automatic send_file(input int count);
		int n;
		n = (count <= 0 || count > file_bytes.size()) ? file_bytes.size() : count;
		for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == 0);
		files_sent++;
		bytes_sent += n;
	endtask

	task automatic make_file(input logic [15:0] magic, input logic [31:0] ofs,
			input logic [31:0] hsz, input logic [31:0] wid, input logic [31:0] hgt,
			input logic [15:0] bpp, input int trail);
		logic [63:0] prod;
		int          row_len;
		int          pad;
		file_bytes.delete();
		for (int i = 0; i <= POS_HDR_END; i++) file_bytes.push_back(8'($urandom));
		file_bytes[0] = magic[7:0];
		file_bytes[1] = magic[15:8];
		file_bytes[POS_BPP_LO] = bpp[7:0];
		file_bytes[POS_BPP_HI] = bpp[15:8];
		for (int k = 0; k < 4; k++) begin
			file_bytes[POS_OFS_LO + k] = ofs[8*k +: 8];
			file_bytes[POS_HSZ_LO + k] = hsz[8*k +: 8];
			file_bytes[POS_W_LO + k] = wid[8*k +: 8];
			file_bytes[POS_H_LO + k] = hgt[8*k +: 8];
		end
		// gap and pixel rows only for well-formed small images
		prod = 64'(bpp) * 64'(wid);
		if (magic == BMP_MAGIC && hsz == HSZ_OK && ofs >= MIN_OFFSET && ofs < 200
				&& wid <= DEF_MAX_WIDTH && hgt <= 8 && prod < 64'd4096) begin
			row_len = int'(prod >> 3);
			pad = (4 - row_len % 4) % 4;
			repeat (ofs - MIN_OFFSET) file_bytes.push_back(8'($urandom));
			repeat (hgt) repeat (row_len + pad) file_bytes.push_back(8'($urandom));
		end
		repeat (trail) file_bytes.push_back(8'($urandom));
	endtask

	task automatic run_file(input logic [15:0] magic, input logic [31:0] ofs,
			input logic [31:0] hsz, input logic [31:0] wid, input logic [31:0] hgt,
			input logic [15:0] bpp, input int trail);
		make_file(magic, ofs, hsz, wid, hgt, bpp, trail);
		send_file(0);
	endtask

	// drop valid, let every expected word drain, then allow for in-flight words
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_fill(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		fill_model = v;
		fill_writes++;
	endtask

	// ---------------------------------------------------------------
	// Receiver pacing: random stalls plus an on-demand long hold-off
	// ---------------------------------------------------------------
	initial begin : sink_pacing
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = 0;
			if (hold_off_cycles != 0) begin
				n = hold_off_cycles;
				hold_off_cycles = 0;
			end else if (pacing && $urandom_range(0, 9) < 3) begin
				n = pick_gap();
			end
			if (n != 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// ---------------------------------------------------------------
	// Output checker
	// ---------------------------------------------------------------
	task automatic compare_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin : check_words
		res_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word, expected none, actual byte=%0h kind=%0d st=%0d last=%0b",
					$time, out_byte, out_kind, status, last);
			end else begin
				want = expected_words.pop_front();
				compare_field("out_byte", want.val, out_byte);
				compare_field("out_kind", 8'(want.kind), 8'(out_kind));
				compare_field("status", 8'(want.status), 8'(status));
				compare_field("last", 8'(want.last), 8'(last));
				words_checked++;
				if (want.kind == KIND_STATUS) status_seen++;
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// bytes without a start flag while idle give nothing
	task automatic test_idle_bytes();
		send_noise(6);
		wait_drained();
	endtask

	// fill byte at its reset value; groups span rows, one-byte tail
	task automatic test_reset_fill();
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 5, 2, 8, 0);
		wait_drained();
	endtask

	task automatic test_fill_extremes();
		logic [7:0] vals[3];
		vals[0] = 8'h00;
		vals[1] = 8'($urandom);
		vals[2] = 8'hFF;
		for (int i = 0; i < 3; i++) begin
			write_fill(vals[i]);
			run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 2, 2, 24, 0);
			wait_drained();
		end
	endtask

	task automatic test_header_checks();
		pacing = 1'b0;
		run_file(16'h424D, MIN_OFFSET, HSZ_OK, 4, 1, 24, 0);
		run_file(16'hCD42, MIN_OFFSET, HSZ_OK, 4, 1, 24, 0);
		run_file(BMP_MAGIC, MIN_OFFSET, 32'd41, 4, 1, 24, 0);
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK + 32'd256, 4, 1, 24, 0);
		// header size is judged ahead of the offset
		run_file(BMP_MAGIC, 32'd0, 32'd12, 4, 1, 24, 0);
		run_file(BMP_MAGIC, MIN_OFFSET - 1, HSZ_OK, 4, 1, 24, 0);
		run_file(BMP_MAGIC, 32'd0, HSZ_OK, 4, 1, 24, 0);
		pacing = 1'b1;
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, DEF_MAX_WIDTH + 1, 1, 24, 0);
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 1, DEF_MAX_HEIGHT + 1, 24, 0);
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 32'hFFFF_FFFF, 1, 24, 0);
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 1, 32'h8000_0000, 24, 0);
		// empty images: zero height, zero width, stride rounding to zero, zero bpp
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, DEF_MAX_WIDTH, 0, 24, 3);
		run_file(BMP_MAGIC, MIN_OFFSET + 6, HSZ_OK, 0, 3, 24, 2);
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 7, 2, 1, 0);
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 5, 2, 0, 0);
		// widest stride, largest size: a few data bytes, then cut off
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, DEF_MAX_WIDTH, DEF_MAX_HEIGHT,
			16'hFFFF, 20);
		// offset far out: skipping never ends before the next start
		run_file(BMP_MAGIC, 32'hFFFF_FFFF, HSZ_OK, 2, 2, 8, 10);
		wait_drained();
	endtask

	task automatic test_pixel_layout();
		write_fill(8'($urandom));
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 1, 1, 24, 0);
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 2, 1, 8, 0);
		run_file(BMP_MAGIC, MIN_OFFSET + 3, HSZ_OK, 1, 3, 32, 0);
		run_file(BMP_MAGIC, MIN_OFFSET + 1, HSZ_OK, 3, 2, 16, 0);
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 3, 4, 4, 0);
		// bytes past the last row are ignored
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 5, 3, 8, 7);
		send_noise(4);
		wait_drained();
	endtask

	// a start flag cuts a file short at any point
	task automatic test_restarts();
		make_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 5, 3, 8, 0);
		send_file(1);
		send_file(2);
		send_file(20);
		send_file(31);
		send_file(int'(POS_HDR_END) + 1 + 3);
		send_file(int'(POS_HDR_END) + 1 + 7);
		make_file(BMP_MAGIC, MIN_OFFSET + 4, HSZ_OK, 5, 3, 8, 0);
		send_file(int'(POS_HDR_END) + 3);
		send_file(0);
		wait_drained();
	endtask

	// receiver holds off while the sender keeps offering bytes
	task automatic test_output_stall();
		pacing = 1'b0;
		hold_off_cycles = 150;
		run_file(BMP_MAGIC, MIN_OFFSET, HSZ_OK, 16, 3, 24, 0);
		wait_drained();
		pacing = 1'b1;
	endtask

	task automatic test_random_files();
		int unsigned stop_at;
		int          sel;
		int          nfiles;
		logic [15:0] magic;
		logic [15:0] bpp;
		logic [31:0] ofs;
		logic [31:0] hsz;
		logic [31:0] wid;
		logic [31:0] hgt;
		// the directed tests already send most of the byte budget
		stop_at = bytes_sent + 400;
		nfiles = 0;
		while (bytes_sent < stop_at) begin
			pacing = ($urandom_range(0, 3) != 0);
			if (nfiles % 4 == 3) begin
				wait_drained();
				case ($urandom_range(0, 3))
					0: write_fill(8'h00);
					1: write_fill(8'hFF);
					default: write_fill(8'($urandom));
				endcase
			end
			magic = BMP_MAGIC;
			hsz = HSZ_OK;
			ofs = MIN_OFFSET + $urandom_range(0, 6);
			wid = $urandom_range(0, 10);
			hgt = $urandom_range(0, 4);
			case ($urandom_range(0, 7))
				0: bpp = 16'd1;
				1: bpp = 16'd4;
				2: bpp = 16'd8;
				3: bpp = 16'd16;
				4: bpp = 16'd24;
				5: bpp = 16'd32;
				6: bpp = 16'($urandom_range(0, 48));
				default: begin
					bpp = 16'd8;
					wid = $urandom_range(11, 40);
				end
			endcase
			// most files well-formed; the rest broken in one field or cut short
			sel = $urandom_range(0, 99);
			if (sel < 4)
				magic = 16'($urandom);
			else if (sel < 8)
				hsz = $urandom_range(0, 1) ? 32'($urandom) : HSZ_OK ^ (32'd1 << $urandom_range(0, 31));
			else if (sel < 11)
				ofs = $urandom_range(0, 53);
			else if (sel < 14)
				wid = $urandom_range(0, 1) ? 32'($urandom) : DEF_MAX_WIDTH + $urandom_range(0, 2);
			else if (sel < 17)
				hgt = $urandom_range(0, 1) ? 32'($urandom) : DEF_MAX_HEIGHT + $urandom_range(0, 2);
			make_file(magic, ofs, hsz, wid, hgt, bpp,
				$urandom_range(0, 3) != 0 ? 0 : $urandom_range(1, 8));
			if (sel >= 17 && sel < 27)
				send_file($urandom_range(1, file_bytes.size()));
			else
				send_file(0);
			if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 6));
			nfiles++;
		end
		wait_drained();
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		clear_decode();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bytes();
		test_reset_fill();
		test_fill_extremes();
		test_header_checks();
		test_pixel_layout();
		test_restarts();
		test_output_stall();
		test_random_files();
		wait_drained();
		$display("Sent %0d files (%0d bytes): header faults, empty images, restarts, stalls",
			files_sent, bytes_sent);
		$display("Checked %0d output words (%0d status words) across %0d fill settings",
			words_checked, status_seen, fill_writes + 1);
		if (mismatches == 0)
			$display("PASS bmp_pixel_stream_decoder");
		else
			$display("FAIL bmp_pixel_stream_decoder");
		$finish;
	end

	// Watchdog
	initial begin
		#(64'd20_000_000);
		$display("FAIL bmp_pixel_stream_decoder");
		$finish;
	end

endmodule
